// ===== design/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg: shared definitions for the Poly1305 block accumulator
// Widths, clamp masks, register indexes, queue item and back-end state type.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Message block and accumulator widths.
  localparam int BLOCK_W     = 128;            // one 16-byte block
  localparam int BLOCK_BYTES = BLOCK_W / 8;
  localparam int MSG_W       = BLOCK_W + 1;    // block plus the high 2^128 bit
  localparam int ACC_W       = 131;            // 128 bits plus a 3-bit top
  localparam int H_W         = 132;            // accumulator plus message
  localparam int PROD_W      = 256;            // product kept modulo 2^256
  localparam int COUNT_W     = 5;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BLOCK_BYTES);

  // Multiplier limbs.
  localparam int LIMB_W  = 32;
  localparam int H_LIMBS = 5;                  // covers the 132-bit sum
  localparam int R_LIMBS = 4;                  // covers the 128-bit key half r
  localparam int HI_W    = $clog2(H_LIMBS);
  localparam int RI_W    = $clog2(R_LIMBS);
  localparam int SH_W    = $clog2(H_LIMBS + R_LIMBS - 1);

  // Key clamp masks.
  localparam logic [63:0] CLAMP_LOW  = 64'h0FFF_FFFC_0FFF_FFFF;
  localparam logic [63:0] CLAMP_HIGH = 64'h0FFF_FFFC_0FFF_FFFC;

  // Configuration register indexes (register i sits at byte address 8*i).
  localparam logic REG_R_LOW  = 1'b0;
  localparam logic REG_R_HIGH = 1'b1;

  // Stream widths, padded to whole bytes.
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 136;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [MSG_W-1:0] msg;    // padded block with the 2^128 bit where due
    logic             clear;  // zero the accumulator before this block
  } pba_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DRAIN,
    BK_FOLD,
    BK_DONE
  } back_state_t;

endpackage

// ===== design/pba_front.sv =====
// ----------------------------------------------------------------------------
// pba_front: input acceptance and block classification
// Saturates the byte count, zero-fills a short block, places the 1 byte
// after its last valid byte, and sets the 2^128 bit for a full block.
// ----------------------------------------------------------------------------
module pba_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pba_pkg::S_DATA_W-1:0]  in_data,
  input  logic                          in_user,
  input  logic                          q_full,
  output logic                          push,
  output pba_pkg::pba_item_t            push_item
);

  logic [pba_pkg::COUNT_W-1:0] n_sat;
  logic [pba_pkg::COUNT_W-1:0] count_in;
  logic [pba_pkg::BLOCK_W-1:0] padded;

  assign count_in = in_data[pba_pkg::BLOCK_W +: pba_pkg::COUNT_W];
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    n_sat = (count_in > pba_pkg::FULL_COUNT) ? pba_pkg::FULL_COUNT : count_in;
    for (int i = 0; i < pba_pkg::BLOCK_BYTES; i++) begin
      if (pba_pkg::COUNT_W'(i) < n_sat) begin
        padded[8*i +: 8] = in_data[8*i +: 8];
      end else if (pba_pkg::COUNT_W'(i) == n_sat) begin
        padded[8*i +: 8] = 8'h01;
      end else begin
        padded[8*i +: 8] = 8'h00;
      end
    end
  end

  assign push_item.msg   = {(n_sat == pba_pkg::FULL_COUNT), padded};
  assign push_item.clear = in_user;

endmodule

// ===== design/pba_queue.sv =====
// ----------------------------------------------------------------------------
// pba_queue: short item queue between front and back
// Keeps classified items so the input side can run ahead of the
// multiply-reduce sequencer.
// ----------------------------------------------------------------------------
module pba_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pba_pkg::pba_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output pba_pkg::pba_item_t pop_item
);

  localparam int PTR_W = $clog2(pba_pkg::QDEPTH);
  localparam int CNT_W = $clog2(pba_pkg::QDEPTH + 1);

  pba_pkg::pba_item_t mem [pba_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(pba_pkg::QDEPTH));
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pba_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pba_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/pba_back.sv =====
// ----------------------------------------------------------------------------
// pba_back: multiply-reduce sequencer
// Adds the block to the accumulator, multiplies by the clamped r with one
// shared 32x32 multiplier over 20 limb products, folds the bits above 2^130
// back in as 4x plus x, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pba_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  pba_pkg::pba_item_t        q_item,
  output logic                      q_pop,
  input  logic [63:0]               r_low,
  input  logic [63:0]               r_high,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pba_pkg::ACC_W-1:0] acc
);

  localparam int X_W    = pba_pkg::PROD_W - 130;
  localparam int FOLD_W = X_W + 3;

  pba_pkg::back_state_t           state;
  pba_pkg::back_state_t           state_next;

  logic [pba_pkg::H_W-1:0]        h;
  logic [pba_pkg::HI_W-1:0]       hi_idx;
  logic [pba_pkg::RI_W-1:0]       r_idx;
  logic [2*pba_pkg::LIMB_W-1:0]   pp;
  logic [pba_pkg::SH_W-1:0]       pp_sh;
  logic                           pp_valid;
  logic [pba_pkg::PROD_W-1:0]     prod;
  logic [FOLD_W-1:0]              fold;

  logic [127:0]                   rc;
  logic [pba_pkg::LIMB_W-1:0]     h_limb;
  logic [pba_pkg::LIMB_W-1:0]     r_limb;
  logic [pba_pkg::ACC_W-1:0]      base;
  logic [X_W-1:0]                 x;
  logic                           last_step;
  logic                           done_fire;

  assign rc     = {r_high & pba_pkg::CLAMP_HIGH, r_low & pba_pkg::CLAMP_LOW};
  assign r_limb = rc[{r_idx, 5'b00000} +: pba_pkg::LIMB_W];
  assign base   = q_item.clear ? '0 : acc;
  assign x      = prod[pba_pkg::PROD_W-1:130];

  always_comb begin
    unique case (hi_idx)
      3'd0:    h_limb = h[31:0];
      3'd1:    h_limb = h[63:32];
      3'd2:    h_limb = h[95:64];
      3'd3:    h_limb = h[127:96];
      3'd4:    h_limb = {28'b0, h[pba_pkg::H_W-1:128]};
      default: h_limb = '0;
    endcase
  end

  assign last_step = (hi_idx == pba_pkg::HI_W'(pba_pkg::H_LIMBS - 1)) &&
                     (r_idx == pba_pkg::RI_W'(pba_pkg::R_LIMBS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pba_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    done_fire  = 1'b0;
    unique case (state)
      pba_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = pba_pkg::BK_MUL;
        end
      end
      pba_pkg::BK_MUL: begin
        if (last_step) begin
          state_next = pba_pkg::BK_DRAIN;
        end
      end
      pba_pkg::BK_DRAIN: begin
        state_next = pba_pkg::BK_FOLD;
      end
      pba_pkg::BK_FOLD: begin
        state_next = pba_pkg::BK_DONE;
      end
      pba_pkg::BK_DONE: begin
        if (!out_valid || out_ready) begin
          done_fire  = 1'b1;
          state_next = pba_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = pba_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath: limb counters, product pipeline and fold.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      h      <= {1'b0, base} + {3'b000, q_item.msg};
      hi_idx <= '0;
      r_idx  <= '0;
    end else if (state == pba_pkg::BK_MUL) begin
      if (r_idx == pba_pkg::RI_W'(pba_pkg::R_LIMBS - 1)) begin
        r_idx  <= '0;
        hi_idx <= hi_idx + 1'b1;
      end else begin
        r_idx <= r_idx + 1'b1;
      end
    end

    pp    <= h_limb * r_limb;
    pp_sh <= pba_pkg::SH_W'(hi_idx) + pba_pkg::SH_W'(r_idx);

    // Each limb product lands at 32 times the sum of its limb indexes.
    if (q_pop) begin
      prod <= '0;
    end else if (pp_valid) begin
      prod <= prod + ({(pba_pkg::PROD_W - 2*pba_pkg::LIMB_W)'(0), pp} << {pp_sh, 5'b00000});
    end

    if (state == pba_pkg::BK_FOLD) begin
      fold <= {1'b0, x, 2'b00} + {3'b000, x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      pp_valid <= (state == pba_pkg::BK_MUL);
      if (done_fire) begin
        acc       <= {1'b0, prod[129:0]} + {2'b00, fold};
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/poly1305_block_accumulate.sv =====
// ----------------------------------------------------------------------------
// poly1305_block_accumulate: Poly1305 message block accumulator
// Absorbs 16-byte blocks into the 131-bit accumulator, h = (h + block) * r
// partially reduced modulo 2^130 - 5, and returns h after every block.
//
//   Channel   Dir  Contents
//   s_axis    in   block_low, block_high, block_bytes; tuser = clear_first
//   m_axis    out  acc_low, acc_mid, acc_top
//   APB       in   r_low at 0x0, r_high at 0x8 (64-bit data)
//
// The back end takes one item at a time: it adds the block, runs 20 limb
// products through the single shared 32x32 multiplier, drains the product
// pipeline, then folds and adds. A two-item queue takes input items every
// cycle while it has room. Reset clears the accumulator, the key registers
// and the queue. A stalled m_axis holds the result and the back end; input
// continues until the queue fills.
// ----------------------------------------------------------------------------
module poly1305_block_accumulate (
  input  logic                         clk,
  input  logic                         rst,
  // block_low [63:0], block_high [127:64], block_bytes [132:128], zero pad
  input  logic [pba_pkg::S_DATA_W-1:0] s_axis_tdata,
  // clear_first [0]
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // acc_low [63:0], acc_mid [127:64], acc_top [130:128], zero pad
  output logic [pba_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  logic [63:0]               r_low;
  logic [63:0]               r_high;
  logic                      q_full;
  logic                      q_push;
  pba_pkg::pba_item_t        push_item;
  logic                      q_valid;
  logic                      q_pop;
  pba_pkg::pba_item_t        pop_item;
  logic [pba_pkg::ACC_W-1:0] acc;

  assign pready = 1'b1;

  // Registers decode on address bit 3; the low address bits are not decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_low  <= '0;
      r_high <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        pba_pkg::REG_R_LOW:  r_low  <= pwdata;
        pba_pkg::REG_R_HIGH: r_high <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      pba_pkg::REG_R_LOW:  prdata = r_low;
      pba_pkg::REG_R_HIGH: prdata = r_high;
    endcase
  end

  pba_front u_front (
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (push_item)
  );

  pba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  pba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .r_low     (r_low),
    .r_high    (r_high),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .acc       (acc)
  );

  assign m_axis_tdata = {(pba_pkg::M_DATA_W - pba_pkg::ACC_W)'(0), acc};

endmodule
